>>> sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
    } entry_t;

endpackage

>>> sv/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to TABLE_DEPTH key/payload entries kept in ascending signed key
// order, with insert, find-all and delete-all operations over one memory.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             fields
//  input    in         in_valid / in_stall   op, key, record_payload
//  output   out        out_valid / out_stall status, found_key, found_payload,
//                                            removed_count, last
//
//  The entry memory is scanned one read per cycle while the scan is not held,
//  with one compare unit on the registered read data. An insert scans from the
//  top down and stops early at its slot; find and delete scan all n entries of
//  a table of n entries. A full-table insert skips the scan. Reset empties the
//  table at once; the memory itself is never cleared. in_stall is high while an
//  operation is in progress. A stalled output holds the scan of a find at the
//  next match.
//
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [OP_W-1:0]           op,
    input  logic signed [KEY_W-1:0]   key,
    input  logic [PAY_W-1:0]          record_payload,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [STAT_W-1:0]         status,
    output logic signed [KEY_W-1:0]   found_key,
    output logic [PAY_W-1:0]          found_payload,
    output logic [COUNT_W-1:0]        removed_count,
    output logic                      last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rdata_reg;

    state_t             state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [PAY_W-1:0]   pay_reg, pay_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      wptr_reg, wptr_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic [CW-1:0]      removed_reg, removed_next;
    logic [AW-1:0]      raddr_reg, raddr_next;
    logic [AW-1:0]      daddr_reg, daddr_next;
    logic               dvld_reg, dvld_next;
    logic               full_reg, full_next;
    logic               pend_vld_reg, pend_vld_next;
    logic [KEY_W-1:0]   pend_key_reg, pend_key_next;
    logic [PAY_W-1:0]   pend_pay_reg, pend_pay_next;

    logic               out_vld_reg, out_vld_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [KEY_W-1:0]   okey_reg, okey_next;
    logic [PAY_W-1:0]   opay_reg, opay_next;
    logic [CW-1:0]      ocount_reg, ocount_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic               match;
    logic               key_ge;
    logic               hold;
    logic               ren;
    logic               wen;
    logic [AW-1:0]      waddr;
    entry_t             wdata;
    entry_t             new_entry;

    assign out_free  = !out_vld_reg || !out_stall;
    assign match     = (rdata_reg.key == key_reg);
    assign key_ge    = ($signed(rdata_reg.key) >= $signed(key_reg));
    assign new_entry = '{key: key_reg, pay: pay_reg};

    // a new find match needs the output when a match is already pending
    assign hold = (state_reg == S_SCAN) && dvld_reg && (op_reg == OP_FIND) &&
                  match && pend_vld_reg && !out_free;
    assign ren  = (state_reg == S_SCAN) && (rem_reg != '0) && !hold;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        cnt_next      = cnt_reg;
        wptr_next     = wptr_reg;
        rem_next      = rem_reg;
        removed_next  = removed_reg;
        raddr_next    = raddr_reg;
        daddr_next    = daddr_reg;
        dvld_next     = dvld_reg;
        full_next     = full_reg;
        pend_vld_next = pend_vld_reg;
        pend_key_next = pend_key_reg;
        pend_pay_next = pend_pay_reg;
        out_vld_next  = out_vld_reg && out_stall;
        status_next   = status_reg;
        okey_next     = okey_reg;
        opay_next     = opay_reg;
        ocount_next   = ocount_reg;
        last_next     = last_reg;
        wen           = 1'b0;
        waddr         = '0;
        wdata         = rdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = op;
                    key_next      = key;
                    pay_next      = record_payload;
                    dvld_next     = 1'b0;
                    pend_vld_next = 1'b0;
                    wptr_next     = '0;
                    full_next     = 1'b0;
                    removed_next  = '0;
                    rem_next      = cnt_reg;
                    raddr_next    = '0;
                    unique case (op)
                        OP_INSERT:
                        begin
                            // scan down from the top entry
                            raddr_next = AW'(cnt_reg - 1'b1);
                            if (cnt_reg == DEPTH_C)
                            begin
                                full_next  = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FIND, OP_DELETE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            // drop unused opcode
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (ren)
                begin
                    rem_next   = rem_reg - 1'b1;
                    daddr_next = raddr_reg;
                    dvld_next  = 1'b1;
                    if (op_reg == OP_INSERT)
                        raddr_next = raddr_reg - 1'b1;
                    else
                        raddr_next = raddr_reg + 1'b1;
                end
                else if (!hold)
                begin
                    dvld_next = 1'b0;
                end

                if (dvld_reg && !hold)
                begin
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            wen   = 1'b1;
                            waddr = AW'(daddr_reg + 1'b1);
                            if (key_ge)
                            begin
                                // shift entry up one slot
                                wdata = rdata_reg;
                            end
                            else
                            begin
                                wdata      = new_entry;
                                cnt_next   = cnt_reg + 1'b1;
                                state_next = S_FIN;
                            end
                        end
                        OP_FIND:
                        begin
                            if (match)
                            begin
                                if (pend_vld_reg)
                                begin
                                    out_vld_next = 1'b1;
                                    status_next  = ST_OK;
                                    okey_next    = pend_key_reg;
                                    opay_next    = pend_pay_reg;
                                    ocount_next  = '0;
                                    last_next    = 1'b0;
                                end
                                pend_vld_next = 1'b1;
                                pend_key_next = rdata_reg.key;
                                pend_pay_next = rdata_reg.pay;
                            end
                        end
                        default:
                        begin
                            // compact kept entries down
                            if (!match)
                            begin
                                wen       = 1'b1;
                                waddr     = wptr_reg[AW-1:0];
                                wdata     = rdata_reg;
                                wptr_next = wptr_reg + 1'b1;
                            end
                        end
                    endcase
                end
                else if (!dvld_reg && (rem_reg == '0))
                begin
                    state_next = S_FIN;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            // every entry moved up: new key goes to the bottom
                            wen      = 1'b1;
                            waddr    = '0;
                            wdata    = new_entry;
                            cnt_next = cnt_reg + 1'b1;
                        end
                        OP_DELETE:
                        begin
                            cnt_next     = wptr_reg;
                            removed_next = cnt_reg - wptr_reg;
                        end
                        default:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    okey_next    = key_reg;
                    opay_next    = '0;
                    ocount_next  = '0;
                    last_next    = 1'b1;
                    status_next  = ST_OK;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            if (full_reg)
                                status_next = ST_FULL;
                        end
                        OP_FIND:
                        begin
                            if (pend_vld_reg)
                            begin
                                okey_next = pend_key_reg;
                                opay_next = pend_pay_reg;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            if (removed_reg == '0)
                                status_next = ST_NOT_FOUND;
                            else
                                ocount_next = removed_reg;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_INSERT;
            key_reg      <= '0;
            pay_reg      <= '0;
            cnt_reg      <= '0;
            wptr_reg     <= '0;
            rem_reg      <= '0;
            removed_reg  <= '0;
            raddr_reg    <= '0;
            daddr_reg    <= '0;
            dvld_reg     <= 1'b0;
            full_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            pend_key_reg <= '0;
            pend_pay_reg <= '0;
            out_vld_reg  <= 1'b0;
            status_reg   <= ST_OK;
            okey_reg     <= '0;
            opay_reg     <= '0;
            ocount_reg   <= '0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            key_reg      <= key_next;
            pay_reg      <= pay_next;
            cnt_reg      <= cnt_next;
            wptr_reg     <= wptr_next;
            rem_reg      <= rem_next;
            removed_reg  <= removed_next;
            raddr_reg    <= raddr_next;
            daddr_reg    <= daddr_next;
            dvld_reg     <= dvld_next;
            full_reg     <= full_next;
            pend_vld_reg <= pend_vld_next;
            pend_key_reg <= pend_key_next;
            pend_pay_reg <= pend_pay_next;
            out_vld_reg  <= out_vld_next;
            status_reg   <= status_next;
            okey_reg     <= okey_next;
            opay_reg     <= opay_next;
            ocount_reg   <= ocount_next;
            last_reg     <= last_next;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wen)
            mem[waddr] <= wdata;
        if (ren)
            rdata_reg <= mem[raddr_reg];
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_vld_reg;
    assign status        = status_reg;
    assign found_key     = $signed(okey_reg);
    assign found_payload = opay_reg;
    assign removed_count = COUNT_W'(ocount_reg);
    assign last          = last_reg;

endmodule
